### sv/bucq_pkg.sv
// ----------------------------------------------------------------------------
// bucq_pkg
// Shared types, request codes and a hex digit helper for the buffered UART char queues.
// ----------------------------------------------------------------------------
package bucq_pkg;

  localparam int unsigned DEPTH_DEF = 256;

  // request codes
  localparam logic [2:0] REQ_LINE_IN  = 3'd0;
  localparam logic [2:0] REQ_HOST_RD  = 3'd1;
  localparam logic [2:0] REQ_CHAR_WR  = 3'd2;
  localparam logic [2:0] REQ_HEX_WR   = 3'd3;
  localparam logic [2:0] REQ_LINE_RDY = 3'd4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [7:0] HEX_DIGITS = 8'd8;

  // controller -> datapath commands
  typedef struct packed {
    logic latch;     // capture the request fields
    logic eval;      // capture the per-request result flags
    logic rx_wr;     // store line byte in the receive ring
    logic rx_rd;     // pop one byte from the receive ring
    logic tx_rd;     // pop one byte from the transmit ring
    logic tx_push;   // push one byte into the transmit ring
    logic load_out;  // load the result register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [2:0] req;
    logic       rx_full;
    logic       rx_empty;
    logic       tx_empty;
    logic       tx_fit;
    logic       is_lf;
  } sts_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h37 + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage

### sv/bucq_in_if.sv
// ----------------------------------------------------------------------------
// bucq_in_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface bucq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  line_byte;
  logic [7:0]  host_char;
  logic [31:0] hex_value;

  modport source (output valid, req_type, line_byte, host_char, hex_value, input ready);
  modport sink   (input valid, req_type, line_byte, host_char, hex_value, output ready);
endinterface

### sv/bucq_out_if.sv
// ----------------------------------------------------------------------------
// bucq_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface bucq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_valid;
  logic [7:0] line_tx_byte;
  logic       line_tx_valid;
  logic       write_accepted;
  logic       rx_dropped;
  logic       tx_irq_enable;

  modport source (output valid, read_byte, read_valid, line_tx_byte, line_tx_valid,
                  write_accepted, rx_dropped, tx_irq_enable, input ready);
  modport sink   (input valid, read_byte, read_valid, line_tx_byte, line_tx_valid,
                  write_accepted, rx_dropped, tx_irq_enable, output ready);
endinterface

### sv/bucq_ctrl.sv
// ----------------------------------------------------------------------------
// bucq_ctrl
// Request sequencer: accept, evaluate, push bytes, hand result to output.
// ----------------------------------------------------------------------------
module bucq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  bucq_pkg::sts_t sts,
  output bucq_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_wr;
  logic       out_free;

  assign is_wr    = (sts.req == bucq_pkg::REQ_CHAR_WR) || (sts.req == bucq_pkg::REQ_HEX_WR);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DONE;
        priority if (sts.req == bucq_pkg::REQ_LINE_IN) begin
          cmd.rx_wr = !sts.rx_full;
        end else if (sts.req == bucq_pkg::REQ_HOST_RD) begin
          cmd.rx_rd = !sts.rx_empty;
        end else if (sts.req == bucq_pkg::REQ_LINE_RDY) begin
          cmd.tx_rd = !sts.tx_empty;
        end else if (is_wr && sts.tx_fit) begin
          state_nxt = S_PUSH;
          if (sts.req == bucq_pkg::REQ_HEX_WR) begin
            cnt_nxt = 3'd7;
          end else if (sts.is_lf) begin
            cnt_nxt = 3'd1;
          end else begin
            cnt_nxt = 3'd0;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PUSH: begin
        cmd.tx_push = 1'b1;
        if (cnt_r == 3'd0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 3'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/bucq_dp.sv
// ----------------------------------------------------------------------------
// bucq_dp
// Ring pointers, receive and transmit byte stores, result register.
// ----------------------------------------------------------------------------
module bucq_dp #(
  parameter int unsigned DEPTH = bucq_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [2:0]     req_type,
  input  logic [7:0]     line_byte,
  input  logic [7:0]     host_char,
  input  logic [31:0]    hex_value,
  input  bucq_pkg::cmd_t cmd,
  output bucq_pkg::sts_t sts,
  output logic [7:0]     read_byte,
  output logic           read_valid,
  output logic [7:0]     line_tx_byte,
  output logic           line_tx_valid,
  output logic           write_accepted,
  output logic           rx_dropped,
  output logic           tx_irq_enable
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = PW + 1;
  localparam int unsigned RW = (CW > 4) ? CW : 4;
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    if (p == PTR_LAST) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  logic [7:0]    rx_mem [DEPTH];
  logic [7:0]    tx_mem [DEPTH];

  logic [PW-1:0] rx_w_r, rx_r_r, tx_w_r, tx_r_r;
  logic [2:0]    req_r;
  logic [7:0]    lbyte_r, char_r;
  logic [31:0]   hex_r;
  logic          cr_pend_r;
  logic [7:0]    rx_rdata_r, tx_rdata_r;
  logic          rd_ok_r, tx_ok_r, acc_r, drop_r;
  logic [7:0]    o_read_byte_r, o_tx_byte_r;
  logic          o_read_valid_r, o_tx_valid_r, o_acc_r, o_drop_r, o_irq_r;

  logic [RW-1:0] tx_used, tx_room, need;
  logic [7:0]    push_byte;

  always_comb begin
    if (tx_w_r >= tx_r_r) begin
      tx_used = RW'(tx_w_r) - RW'(tx_r_r);
    end else begin
      tx_used = RW'(tx_w_r) + RW'(DEPTH) - RW'(tx_r_r);
    end
    tx_room = RW'(DEPTH - 1) - tx_used;
    if (req_r == bucq_pkg::REQ_HEX_WR) begin
      need = RW'(bucq_pkg::HEX_DIGITS);
    end else if (char_r == bucq_pkg::CH_LF) begin
      need = RW'(2);
    end else begin
      need = RW'(1);
    end
  end

  assign sts.req      = req_r;
  assign sts.rx_full  = (ptr_next(rx_w_r) == rx_r_r);
  assign sts.rx_empty = (rx_w_r == rx_r_r);
  assign sts.tx_empty = (tx_w_r == tx_r_r);
  assign sts.tx_fit   = (need <= tx_room);
  assign sts.is_lf    = (char_r == bucq_pkg::CH_LF);

  always_comb begin
    if (req_r == bucq_pkg::REQ_HEX_WR) begin
      push_byte = bucq_pkg::hex_digit(hex_r[31:28]);
    end else if (cr_pend_r) begin
      push_byte = bucq_pkg::CH_CR;
    end else begin
      push_byte = char_r;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_w_r <= '0;
      rx_r_r <= '0;
      tx_w_r <= '0;
      tx_r_r <= '0;
    end else begin
      if (cmd.rx_wr)   rx_w_r <= ptr_next(rx_w_r);
      if (cmd.rx_rd)   rx_r_r <= ptr_next(rx_r_r);
      if (cmd.tx_push) tx_w_r <= ptr_next(tx_w_r);
      if (cmd.tx_rd)   tx_r_r <= ptr_next(tx_r_r);
    end
  end

  // receive store
  always_ff @(posedge clk) begin
    if (cmd.rx_wr) begin
      rx_mem[rx_w_r] <= lbyte_r;
    end
    if (cmd.rx_rd) begin
      rx_rdata_r <= rx_mem[rx_r_r];
    end
  end

  // transmit store
  always_ff @(posedge clk) begin
    if (cmd.tx_push) begin
      tx_mem[tx_w_r] <= push_byte;
    end
    if (cmd.tx_rd) begin
      tx_rdata_r <= tx_mem[tx_r_r];
    end
  end

  // request capture and digit shifter
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r     <= req_type;
      lbyte_r   <= line_byte;
      char_r    <= host_char;
      hex_r     <= hex_value;
      cr_pend_r <= (host_char == bucq_pkg::CH_LF);
    end else if (cmd.tx_push) begin
      hex_r     <= {hex_r[27:0], 4'h0};
      cr_pend_r <= 1'b0;
    end
  end

  // per-request flags
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rd_ok_r <= cmd.rx_rd;
      tx_ok_r <= cmd.tx_rd;
      drop_r  <= (req_r == bucq_pkg::REQ_LINE_IN) && sts.rx_full;
      acc_r   <= ((req_r == bucq_pkg::REQ_CHAR_WR) || (req_r == bucq_pkg::REQ_HEX_WR))
                 && sts.tx_fit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_read_byte_r  <= rd_ok_r ? rx_rdata_r : 8'h00;
      o_read_valid_r <= rd_ok_r;
      o_tx_byte_r    <= tx_ok_r ? tx_rdata_r : 8'h00;
      o_tx_valid_r   <= tx_ok_r;
      o_acc_r        <= acc_r;
      o_drop_r       <= drop_r;
      o_irq_r        <= (tx_w_r != tx_r_r);
    end
  end

  assign read_byte      = o_read_byte_r;
  assign read_valid     = o_read_valid_r;
  assign line_tx_byte   = o_tx_byte_r;
  assign line_tx_valid  = o_tx_valid_r;
  assign write_accepted = o_acc_r;
  assign rx_dropped     = o_drop_r;
  assign tx_irq_enable  = o_irq_r;

endmodule

### sv/buffered_uart_char_queues.sv
// Sequence: a request is taken in idle, evaluated, its bytes pushed (writes
//   only) and its result staged; only then is a new request taken.
// A hex write pushes its digits through the single write port of the transmit
//   store (one digit per cycle).
// Reset: synchronous active-low rst_n empties both rings (pointers to zero) and
//   drops any pending result; ring store contents are left as they are.
// ----------------------------------------------------------------------------
// buffered_uart_char_queues
// Receive and transmit byte rings between a serial line and a host, with
// newline expansion and hex word printing on the transmit side.
// ----------------------------------------------------------------------------
module buffered_uart_char_queues #(
  parameter int unsigned DEPTH = bucq_pkg::DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  bucq_in_if.sink     in_ch,
  bucq_out_if.source  out_ch
);

  bucq_pkg::cmd_t cmd;
  bucq_pkg::sts_t sts;

  // Controller: one request at a time. It takes a transfer in idle, evaluates
  // ring status, steps through byte pushes, then waits for the result register
  // to free up. The result register decouples the output side, so a new
  // request is taken while an earlier result still waits downstream.
  bucq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: two rings with one write and one read port each, request
  // capture, hex digit shifter and the result payload register.
  bucq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_type       (in_ch.req_type),
    .line_byte      (in_ch.line_byte),
    .host_char      (in_ch.host_char),
    .hex_value      (in_ch.hex_value),
    .cmd            (cmd),
    .sts            (sts),
    .read_byte      (out_ch.read_byte),
    .read_valid     (out_ch.read_valid),
    .line_tx_byte   (out_ch.line_tx_byte),
    .line_tx_valid  (out_ch.line_tx_valid),
    .write_accepted (out_ch.write_accepted),
    .rx_dropped     (out_ch.rx_dropped),
    .tx_irq_enable  (out_ch.tx_irq_enable)
  );

  // Never overwrite a result that has not been transferred.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result register loaded while occupied");

  // A result reports at most one outcome.
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($countones({out_ch.read_valid, out_ch.line_tx_valid,
                                  out_ch.write_accepted, out_ch.rx_dropped}) <= 1))
    else $error("result carries more than one outcome");

  // A push cycle touches no other ring port and keeps the input closed.
  a_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tx_push |-> !(cmd.rx_wr || cmd.rx_rd || cmd.tx_rd || in_ch.ready))
    else $error("transmit push overlaps another ring access");

  // Taking a request closes the input until the result is staged.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second request taken while one is in flight");

endmodule
